FILE: hw/rtl/key_matrix_debounce_assert.svh
// ----------------------------------------------------------------------------
// key_matrix_debounce_assert
// assertion macros used by the key matrix debounce checker
// ----------------------------------------------------------------------------
`ifndef KEY_MATRIX_DEBOUNCE_ASSERT_SVH
`define KEY_MATRIX_DEBOUNCE_ASSERT_SVH

// property checked outside reset
`define KMD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// property checked on every edge, reset included
`define KMD_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`endif

FILE: hw/rtl/kmd_pkg.sv
// ----------------------------------------------------------------------------
// kmd_pkg
// shared constants and beat types of the key matrix debounce block
// ----------------------------------------------------------------------------
`default_nettype none

package kmd_pkg;

   localparam int ROWS      = 7;
   localparam int COLS      = 12;
   localparam int COL_W     = 4;
   localparam int TIME_W    = 32;
   localparam int DEB_W     = 16;
   localparam int QDEPTH    = 2;
   localparam int QCNT_W    = 2;

   localparam logic [DEB_W-1:0] DEB_RESET = DEB_W'(10);
   localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(COLS);
   localparam logic [QCNT_W-1:0] QFULL    = QCNT_W'(QDEPTH);

   typedef struct packed {
      logic [COL_W-1:0]  column;
      logic [ROWS-1:0]   row_levels;
      logic [TIME_W-1:0] now_ms;
      logic              in_range;
   } cmd_type;

   typedef struct packed {
      logic [COL_W-1:0] out_column;
      logic [ROWS-1:0]  pressed_rows;
      logic [ROWS-1:0]  changed_rows;
      logic             any_change;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hw/rtl/key_matrix_debounce.sv
// ----------------------------------------------------------------------------
// key_matrix_debounce
// debounces a 7 row by 12 column key matrix, one scanned column per beat
// ----------------------------------------------------------------------------
// Each request beat carries a column index, its raw row levels (0 = pressed)
// and the millisecond time; each yields one response beat with the column's
// debounced pressed mask, changed mask and an any-change flag. A press counts
// at once; a release counts once the wrapping time since the press exceeds
// the debounce setting (csr_debounce_ms, 10 after reset). Columns 12 and up
// leave the state alone and answer with empty masks. One beat per clock is
// sustained while responses are popped as they arrive; a beat passes from the
// request queue through the combinational column update into the response
// queue, and a full response queue stalls the update.
// Key state is held in flip-flops and is ready right out of reset. The csr
// port is always ready and must only be written while idle.
`default_nettype none

module key_matrix_debounce (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_push,
   output      logic                       req_full,
   input  wire logic [kmd_pkg::COL_W-1:0]  req_column,
   input  wire logic [kmd_pkg::ROWS-1:0]   req_row_levels,
   input  wire logic [kmd_pkg::TIME_W-1:0] req_now_ms,
   output      logic                       rsp_empty,
   input  wire logic                       rsp_pop,
   output      logic [kmd_pkg::COL_W-1:0]  rsp_out_column,
   output      logic [kmd_pkg::ROWS-1:0]   rsp_pressed_rows,
   output      logic [kmd_pkg::ROWS-1:0]   rsp_changed_rows,
   output      logic                       rsp_any_change,
   input  wire logic                       csr_valid,
   output      logic                       csr_ready,
   input  wire logic [kmd_pkg::DEB_W-1:0]  csr_debounce_ms
);
   import kmd_pkg::*;

   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd;
   rsp_type rsp;

   kmd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_column     (req_column),
      .req_row_levels (req_row_levels),
      .req_now_ms     (req_now_ms),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_take       (cmd_take)
   );

   kmd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_take        (cmd_take),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_debounce_ms (csr_debounce_ms),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp             (rsp)
   );

   assign rsp_out_column   = rsp.out_column;
   assign rsp_pressed_rows = rsp.pressed_rows;
   assign rsp_changed_rows = rsp.changed_rows;
   assign rsp_any_change   = rsp.any_change;

endmodule

`default_nettype wire

FILE: hw/rtl/kmd_front.sv
// ----------------------------------------------------------------------------
// kmd_front
// accepts scan beats, checks the column range and queues them for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module kmd_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_push,
   output      logic                     req_full,
   input  wire logic [kmd_pkg::COL_W-1:0]  req_column,
   input  wire logic [kmd_pkg::ROWS-1:0]   req_row_levels,
   input  wire logic [kmd_pkg::TIME_W-1:0] req_now_ms,
   output      logic                     cmd_valid,
   output      kmd_pkg::cmd_type         cmd,
   input  wire logic                     cmd_take
);
   import kmd_pkg::*;

   cmd_type           q_ff [QDEPTH];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              push_ok;
   logic              pop_ok;
   cmd_type           entry;

   assign req_full  = (cnt_ff == QFULL);
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_take && cmd_valid;

   // classify the column on the way in
   always_comb begin
      entry.column     = req_column;
      entry.row_levels = req_row_levels;
      entry.now_ms     = req_now_ms;
      entry.in_range   = (req_column < COL_LIMIT);
   end

   always_comb begin
      wr_ptr_in = push_ok ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_ok && !pop_ok) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (pop_ok && !push_ok) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/kmd_back.sv
// ----------------------------------------------------------------------------
// kmd_back
// per-column key state update and result queue
// ----------------------------------------------------------------------------
`default_nettype none

module kmd_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      cmd_valid,
   input  wire kmd_pkg::cmd_type          cmd,
   output      logic                      cmd_take,
   input  wire logic                      csr_valid,
   output      logic                      csr_ready,
   input  wire logic [kmd_pkg::DEB_W-1:0] csr_debounce_ms,
   output      logic                      rsp_empty,
   input  wire logic                      rsp_pop,
   output      kmd_pkg::rsp_type          rsp
);
   import kmd_pkg::*;

   logic [DEB_W-1:0]  deb_ff;
   logic [ROWS-1:0]   down_ff [COLS];
   logic [ROWS-1:0][TIME_W-1:0] stamp_ff [COLS];

   logic [ROWS-1:0]   row_down;
   logic [ROWS-1:0]   down_in;
   logic [ROWS-1:0]   change;
   logic [TIME_W-1:0] stamp_in [ROWS];
   logic [TIME_W-1:0] limit;
   logic              fire;
   rsp_type           result;

   rsp_type           q_ff [QDEPTH];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              pop_ok;

   assign csr_ready = 1'b1;
   assign fire      = cmd_valid && (cnt_ff != QFULL);
   assign cmd_take  = fire;
   assign limit     = {{(TIME_W-DEB_W){1'b0}}, deb_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         deb_ff <= DEB_RESET;
      end else if (csr_valid && csr_ready) begin
         deb_ff <= csr_debounce_ms;
      end
   end

   // one lane per row
   always_comb begin
      row_down = cmd.in_range ? down_ff[cmd.column] : '0;
      for (int r = 0; r < ROWS; r++) begin
         down_in[r]  = row_down[r];
         change[r]   = 1'b0;
         stamp_in[r] = stamp_ff[cmd.column][r];
         if (!cmd.row_levels[r] && !row_down[r]) begin
            down_in[r]  = 1'b1;
            change[r]   = 1'b1;
            stamp_in[r] = cmd.now_ms;
         end else if (cmd.row_levels[r] && row_down[r]) begin
            if ((cmd.now_ms - stamp_ff[cmd.column][r]) > limit) begin
               down_in[r] = 1'b0;
               change[r]  = 1'b1;
            end
         end
      end
      result.out_column = cmd.column;
      result.pressed_rows = cmd.in_range ? down_in : '0;
      result.changed_rows = cmd.in_range ? change : '0;
      result.any_change   = cmd.in_range && (change != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < COLS; c++) begin
            down_ff[c] <= '0;
         end
      end else if (fire && cmd.in_range) begin
         down_ff[cmd.column] <= down_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && cmd.in_range) begin
         for (int r = 0; r < ROWS; r++) begin
            stamp_ff[cmd.column][r] <= stamp_in[r];
         end
      end
   end

   // result queue
   assign rsp_empty = (cnt_ff == '0);
   assign rsp       = q_ff[rd_ptr_ff];
   assign pop_ok    = rsp_pop && !rsp_empty;

   always_comb begin
      wr_ptr_in = fire ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (fire && !pop_ok) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (pop_ok && !fire) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         q_ff[wr_ptr_ff] <= result;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/key_matrix_debounce_checker.sv
// ----------------------------------------------------------------------------
// key_matrix_debounce_checker
// port-level checks of the key matrix debounce block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "key_matrix_debounce_assert.svh"

module key_matrix_debounce_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       rsp_empty,
   input wire logic                       rsp_pop,
   input wire logic [kmd_pkg::COL_W-1:0]  rsp_out_column,
   input wire logic [kmd_pkg::ROWS-1:0]   rsp_pressed_rows,
   input wire logic [kmd_pkg::ROWS-1:0]   rsp_changed_rows,
   input wire logic                       rsp_any_change
);
   import kmd_pkg::*;

   // nothing to deliver right after reset
   `KMD_ASSERT_ALWAYS(a_empty_after_reset, clock, $past(reset) |-> rsp_empty)

   // flag agrees with the changed mask
   `KMD_ASSERT(a_any_change, clock, reset,
      !rsp_empty |-> (rsp_any_change == (rsp_changed_rows != '0)))

   // unknown column answers with empty masks
   `KMD_ASSERT(a_bad_column, clock, reset,
      (!rsp_empty && (rsp_out_column >= COL_LIMIT)) |->
         (rsp_pressed_rows == '0 && rsp_changed_rows == '0))

   // a waiting beat holds
   `KMD_ASSERT(a_rsp_hold, clock, reset,
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_out_column)
         && $stable(rsp_pressed_rows) && $stable(rsp_changed_rows)))

endmodule

bind key_matrix_debounce key_matrix_debounce_checker u_checker (.*);

`default_nettype wire
